// ===== design/length_prefixed_frame_splitter_top_assert.svh =====
// Assertion macros used by the frame splitter RTL.
`ifndef LENGTH_PREFIXED_FRAME_SPLITTER_TOP_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_SPLITTER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LPFS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define LPFS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define LPFS_ASSERT_SAME(label, ante, cons)
`define LPFS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/lpfs_pkg.sv =====
// Package with the constants and codes of the frame splitter.
`default_nettype none
package lpfs_pkg;
	localparam int HEADER_BYTES_DEF = 4;
	localparam int LENGTH_W = 32;

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_END = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	localparam logic [2:0] RK_HEADER = 3'd0;
	localparam logic [2:0] RK_CONTENT = 3'd1;
	localparam logic [2:0] RK_EMPTY = 3'd2;
	localparam logic [2:0] RK_CLEAN = 3'd3;
	localparam logic [2:0] RK_UNEXPECTED = 3'd4;
	localparam logic [2:0] RK_DROPPED = 3'd5;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_CONTENT = 2'd2;
	localparam logic [1:0] PH_ERROR = 2'd3;
endpackage
`default_nettype wire

// ===== design/lpfs_in_if.sv =====
// Channel interface carrying stream items into the frame splitter.
`default_nettype none
interface lpfs_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink (input valid, input kind, input data_byte, output ready);
endinterface
`default_nettype wire

// ===== design/lpfs_out_if.sv =====
// Channel interface carrying results out of the frame splitter.
`default_nettype none
interface lpfs_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  result_kind;
	logic [7:0]  content_byte;
	logic        first_of_frame;
	logic        last_of_frame;
	logic [31:0] frame_length;
	logic        ended_in_header;
	logic [31:0] missing_bytes;

	modport source (output valid, output result_kind, output content_byte,
		output first_of_frame, output last_of_frame, output frame_length,
		output ended_in_header, output missing_bytes, input ready);
	modport sink (input valid, input result_kind, input content_byte,
		input first_of_frame, input last_of_frame, input frame_length,
		input ended_in_header, input missing_bytes, output ready);
endinterface
`default_nettype wire

// ===== design/length_prefixed_frame_splitter_top.sv =====
// Top level of the length-prefixed frame splitter.
`default_nettype none
`include "length_prefixed_frame_splitter_top_assert.svh"
// The splitter takes one stream item per clock while input ready is high and
// delivers its result from a single result register in the cycle after the
// transaction; the decoder state is updated in the same cycle. Input
// ready is high whenever the result register is empty or its result is taken
// in that cycle, so items flow back to back while the consumer keeps up; a
// result that waits untaken holds the input off until it leaves.
// Items of the unused kind are accepted and give no result.
module length_prefixed_frame_splitter_top
	import lpfs_pkg::*;
#(
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	lpfs_in_if.sink    bytes,
	lpfs_out_if.source results
);
	localparam int CNT_W = $clog2(HEADER_BYTES + 1);

	logic [1:0]          phase_q;
	logic [CNT_W-1:0]    seen_q;
	logic [LENGTH_W-1:0] len_q;
	logic [LENGTH_W-1:0] cont_q;

	logic [1:0]          phase_d;
	logic [CNT_W-1:0]    seen_d;
	logic [LENGTH_W-1:0] len_d;
	logic [LENGTH_W-1:0] cont_d;

	logic                emit;
	logic [2:0]          r_kind;
	logic [7:0]          r_byte;
	logic                r_first;
	logic                r_last;
	logic [LENGTH_W-1:0] r_flen;
	logic                r_inhdr;
	logic [LENGTH_W-1:0] r_miss;

	logic [LENGTH_W-1:0] base_len;
	logic [CNT_W-1:0]    base_seen;
	logic [CNT_W-1:0]    seen_inc;
	logic [LENGTH_W-1:0] shifted;
	logic [LENGTH_W-1:0] cont_inc;

	logic                out_valid_q;
	logic [2:0]          kind_q;
	logic [7:0]          byte_q;
	logic                first_q;
	logic                last_q;
	logic [LENGTH_W-1:0] flen_q;
	logic                inhdr_q;
	logic [LENGTH_W-1:0] miss_q;

	logic accept;

	assign bytes.ready = !out_valid_q || results.ready;
	assign accept = bytes.valid && bytes.ready;

	always_comb begin
		phase_d = phase_q;
		seen_d = seen_q;
		len_d = len_q;
		cont_d = cont_q;
		emit = 1'b1;
		r_kind = RK_DROPPED;
		r_byte = 8'd0;
		r_first = 1'b0;
		r_last = 1'b0;
		r_flen = '0;
		r_inhdr = 1'b0;
		r_miss = '0;
		base_len = (phase_q == PH_IDLE) ? '0 : len_q;
		base_seen = (phase_q == PH_IDLE) ? '0 : seen_q;
		seen_inc = CNT_W'(base_seen + 1'b1);
		shifted = {base_len[LENGTH_W-9:0], bytes.data_byte};
		cont_inc = cont_q + 1'b1;
		case (bytes.kind)
			KIND_REJECT: begin
				phase_d = PH_ERROR;
			end
			KIND_END: begin
				case (phase_q)
					PH_IDLE: begin
						r_kind = RK_CLEAN;
					end
					PH_HEADER: begin
						r_kind = RK_UNEXPECTED;
						r_inhdr = 1'b1;
						r_miss = LENGTH_W'(HEADER_BYTES) - LENGTH_W'(seen_q);
						phase_d = PH_ERROR;
					end
					PH_CONTENT: begin
						r_kind = RK_UNEXPECTED;
						r_flen = len_q;
						r_miss = len_q - cont_q;
						phase_d = PH_ERROR;
					end
					default: begin
						r_kind = RK_DROPPED;
					end
				endcase
			end
			KIND_BYTE: begin
				if (phase_q inside {PH_IDLE, PH_HEADER}) begin
					len_d = shifted;
					r_kind = RK_HEADER;
					if (seen_inc >= CNT_W'(HEADER_BYTES)) begin
						seen_d = '0;
						cont_d = '0;
						if (shifted == '0) begin
							phase_d = PH_IDLE;
							r_kind = RK_EMPTY;
							r_last = 1'b1;
						end else begin
							phase_d = PH_CONTENT;
						end
					end else begin
						seen_d = seen_inc;
						phase_d = PH_HEADER;
					end
				end else if (phase_q == PH_CONTENT) begin
					r_kind = RK_CONTENT;
					r_byte = bytes.data_byte;
					r_first = (cont_q == '0);
					r_last = (cont_inc == len_q);
					r_flen = len_q;
					if (cont_inc == len_q) begin
						cont_d = '0;
						phase_d = PH_IDLE;
					end else begin
						cont_d = cont_inc;
					end
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			seen_q <= '0;
			len_q <= '0;
			cont_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase_d;
				seen_q <= seen_d;
				len_q <= len_d;
				cont_q <= cont_d;
				out_valid_q <= emit;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			kind_q <= r_kind;
			byte_q <= r_byte;
			first_q <= r_first;
			last_q <= r_last;
			flen_q <= r_flen;
			inhdr_q <= r_inhdr;
			miss_q <= r_miss;
		end
	end

	assign results.valid = out_valid_q;
	assign results.result_kind = kind_q;
	assign results.content_byte = byte_q;
	assign results.first_of_frame = first_q;
	assign results.last_of_frame = last_q;
	assign results.frame_length = flen_q;
	assign results.ended_in_header = inhdr_q;
	assign results.missing_bytes = miss_q;

	`LPFS_ASSERT_NEXT(a_error_drops, accept && phase_q == PH_ERROR && bytes.kind == KIND_BYTE,
		results.valid && results.result_kind == RK_DROPPED)
	`LPFS_ASSERT_SAME(a_content_in_range, phase_q == PH_CONTENT, cont_q < len_q)
	`LPFS_ASSERT_NEXT(a_none_no_result, accept && bytes.kind == KIND_NONE, !results.valid)
endmodule
`default_nettype wire
